[design/swm_pkg.sv]
// shared types and constants of the sliding-window median core
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int OUT_W      = 33;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int SIZE_W     = 7;
    localparam int ADDR_W     = 2;
    localparam int PDATA_W    = 32;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);
    localparam logic [ADDR_W-1:0] REG_WINDOW_SIZE = ADDR_W'(0);

    // value and age held by one cell
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]         age;
    } swm_tap_t;

    // window with the leaving sample taken out, as seen at one position
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]         age;
        logic                     gt;
    } swm_link_t;

    // broadcast to every cell
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     upd;
        logic                     full;
        logic [IDX_W-1:0]         k_m1;
        logic [CNT_W-1:0]         n_kept;
    } swm_ctrl_t;

    // from the register block
    typedef struct packed {
        logic              wr;
        logic [CNT_W-1:0]  k;
        logic [IDX_W-1:0]  k_m1;
    } swm_cfg_t;

endpackage

[design/swm_cfg.sv]
// register block: window size register and its effective value
module swm_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]     paddr,
    input  logic [swm_pkg::PDATA_W-1:0]    pwdata,
    output logic [swm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output swm_pkg::swm_cfg_t              cfg
);

    logic [swm_pkg::SIZE_W-1:0] size_reg;
    logic [swm_pkg::SIZE_W-1:0] size_next;
    logic                       wr_en;
    logic [swm_pkg::CNT_W-1:0]  k_eff;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr == swm_pkg::REG_WINDOW_SIZE);

    // register write
    always_comb
    begin
        size_next = size_reg;
        if (wr_en)
        begin
            size_next = pwdata[swm_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= swm_pkg::SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr == swm_pkg::REG_WINDOW_SIZE)
        begin
            prdata = swm_pkg::PDATA_W'(size_reg);
        end
    end

    // zero acts as one, anything above the cell count as the cell count
    always_comb
    begin
        if (size_reg == '0)
        begin
            k_eff = swm_pkg::CNT_W'(1);
        end
        else if (swm_pkg::CNT_W'(size_reg) > swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX))
        begin
            k_eff = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
        end
        else
        begin
            k_eff = swm_pkg::CNT_W'(size_reg);
        end
    end

    assign cfg.wr   = wr_en;
    assign cfg.k    = k_eff;
    assign cfg.k_m1 = swm_pkg::IDX_W'(k_eff - swm_pkg::CNT_W'(1));

endmodule

[design/swm_cell.sv]
// one cell of the sorted chain: holds a value and its age in the window
module swm_cell
(
    input  logic                       clk,
    input  logic [swm_pkg::IDX_W-1:0]  pos,
    input  swm_pkg::swm_ctrl_t         ctrl,
    input  logic                       below_dead,
    input  swm_pkg::swm_tap_t          right_tap,
    input  swm_pkg::swm_link_t         left_link,
    input  logic                       left_en,
    output swm_pkg::swm_tap_t          tap,
    output swm_pkg::swm_link_t         link,
    output logic                       dead
);

    logic signed [swm_pkg::DATA_W-1:0] val_reg;
    logic signed [swm_pkg::DATA_W-1:0] val_next;
    logic [swm_pkg::IDX_W-1:0]         age_reg;
    logic [swm_pkg::IDX_W-1:0]         age_next;
    logic                              shift_down;
    logic                              kept_valid;
    logic signed [swm_pkg::DATA_W-1:0] w_val;
    logic [swm_pkg::IDX_W-1:0]         w_age;

    assign tap.val = val_reg;
    assign tap.age = age_reg;

    // this cell holds the sample that leaves the window
    assign dead = ctrl.full && (pos <= ctrl.k_m1) && (age_reg == ctrl.k_m1);

    // close the gap left by the leaving sample
    assign shift_down = below_dead || dead;
    assign w_val      = shift_down ? right_tap.val : val_reg;
    assign w_age      = shift_down ? right_tap.age : age_reg;
    assign kept_valid = swm_pkg::CNT_W'(pos) < ctrl.n_kept;

    assign link.val = w_val;
    assign link.age = w_age;
    assign link.gt  = !kept_valid || (w_val > ctrl.sample);

    // insert the new sample at its sorted place
    always_comb
    begin
        val_next = val_reg;
        age_next = age_reg;
        if (ctrl.upd)
        begin
            if (left_en && left_link.gt)
            begin
                val_next = left_link.val;
                age_next = left_link.age + swm_pkg::IDX_W'(1);
            end
            else if (link.gt)
            begin
                val_next = ctrl.sample;
                age_next = '0;
            end
            else
            begin
                val_next = w_val;
                age_next = w_age + swm_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

endmodule

[design/sliding_window_median_core.sv]
// top level of the sliding-window median core: cell chain, control and output word
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  s       | in        | s_tvalid / s_tready    | s_tdata = sample, s_tuser = start_req
//  m       | out       | m_tvalid / m_tready    | m_tdata = median_doubled (33 bits)
//  apb     | in        | psel, penable, pwrite  | window_size at byte address 0
//
//  one sample is taken per cycle while s_tready is high: all cells remove the leaving
//  sample and insert the new one in the same cycle; the median is then held pending
//  and registered into the output register once the output slot is free. s_tready
//  drops only while a median is pending behind a stalled output word. reset empties
//  the window and sets the size to 3; a size write or a start flag empties it too.
module sliding_window_median_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [swm_pkg::DATA_W-1:0]          s_tdata,   // [31:0] sample
    input  logic                                s_tuser,   // [0] start_req
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swm_pkg::OUT_BYTES_W-1:0]     m_tdata,   // [32:0] median_doubled, zero pad
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swm_pkg::ADDR_W-1:0]          paddr,
    input  logic [swm_pkg::PDATA_W-1:0]         pwdata,
    output logic [swm_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int N = swm_pkg::WINDOW_MAX;

    swm_pkg::swm_cfg_t   cfg;
    swm_pkg::swm_ctrl_t  ctrl;
    swm_pkg::swm_tap_t   taps  [N];
    swm_pkg::swm_link_t  links [N];
    logic [N-1:0]        dead_vec;
    logic [N-1:0]        below_vec;

    logic [swm_pkg::CNT_W-1:0] fill_reg;
    logic [swm_pkg::CNT_W-1:0] fill_next;
    logic [swm_pkg::CNT_W-1:0] fill_eff;
    logic                      pend_reg;
    logic                      pend_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [swm_pkg::OUT_W-1:0] out_reg;
    logic signed [swm_pkg::OUT_W-1:0] out_next;
    logic                      accept;
    logic                      slot_free;
    logic                      full;
    logic                      gives_result;
    logic [swm_pkg::IDX_W-1:0] idx_lo;
    logic [swm_pkg::IDX_W-1:0] idx_hi;
    logic signed [swm_pkg::DATA_W-1:0] mid_lo;
    logic signed [swm_pkg::DATA_W-1:0] mid_hi;

    swm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = !pend_reg || slot_free;
    assign accept    = s_tvalid && s_tready;

    // window fill state for this sample
    assign fill_eff     = s_tuser ? '0 : fill_reg;
    assign full         = fill_eff == cfg.k;
    assign gives_result = full || ((fill_eff + swm_pkg::CNT_W'(1)) == cfg.k);

    assign ctrl.sample = s_tdata;
    assign ctrl.upd    = accept;
    assign ctrl.full   = full;
    assign ctrl.k_m1   = cfg.k_m1;
    assign ctrl.n_kept = full ? (cfg.k - swm_pkg::CNT_W'(1)) : fill_eff;

    // which cells lie above the leaving sample
    always_comb
    begin
        below_vec[0] = 1'b0;
        for (int i = 1; i < N; i++)
        begin
            below_vec[i] = |(dead_vec & ((N'(1) << i) - N'(1)));
        end
    end

    // the cell chain
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        swm_pkg::swm_tap_t  r_tap;
        swm_pkg::swm_link_t l_link;

        if (g == N - 1)
        begin : g_last
            assign r_tap = '0;
        end
        else
        begin : g_mid
            assign r_tap = taps[g+1];
        end

        if (g == 0)
        begin : g_first
            assign l_link = '0;
        end
        else
        begin : g_rest
            assign l_link = links[g-1];
        end

        swm_cell u_cell
        (
            .clk        (clk),
            .pos        (swm_pkg::IDX_W'(g)),
            .ctrl       (ctrl),
            .below_dead (below_vec[g]),
            .right_tap  (r_tap),
            .left_link  (l_link),
            .left_en    (g != 0),
            .tap        (taps[g]),
            .link       (links[g]),
            .dead       (dead_vec[g])
        );
    end

    // middle positions of the window
    assign idx_hi = cfg.k[swm_pkg::CNT_W-1:1];
    assign idx_lo = cfg.k[0] ? idx_hi : (idx_hi - swm_pkg::IDX_W'(1));

    always_comb
    begin
        mid_lo = '0;
        mid_hi = '0;
        for (int i = 0; i < N; i++)
        begin
            if (swm_pkg::IDX_W'(i) == idx_lo)
            begin
                mid_lo = taps[i].val;
            end
            if (swm_pkg::IDX_W'(i) == idx_hi)
            begin
                mid_hi = taps[i].val;
            end
        end
    end

    // fill count, pending median and output word
    always_comb
    begin
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            out_next       = swm_pkg::OUT_W'(mid_lo) + swm_pkg::OUT_W'(mid_hi);
            pend_next      = 1'b0;
        end
        if (accept)
        begin
            fill_next = full ? fill_eff : (fill_eff + swm_pkg::CNT_W'(1));
            pend_next = gives_result;
        end
        if (cfg.wr)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = swm_pkg::OUT_BYTES_W'($unsigned(out_reg));

endmodule
